FILE: hdl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the banker safety allocator
// Table sizes, opcodes, result codes, lane commands and saturating add.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int MAX_PROCS = 8;
   localparam int MAX_RES   = 6;
   localparam int UNIT_W    = 12;
   localparam int ROW_W     = $clog2(MAX_PROCS);

   localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};

   // input opcodes
   localparam logic [2:0] OP_LOAD_AV  = 3'd0;
   localparam logic [2:0] OP_LOAD_AL  = 3'd1;
   localparam logic [2:0] OP_LOAD_ND  = 3'd2;
   localparam logic [2:0] OP_CHECK    = 3'd3;
   localparam logic [2:0] OP_REQUEST  = 3'd4;

   // result status codes
   localparam logic [2:0] ST_LOADED    = 3'd0;
   localparam logic [2:0] ST_GRANTED   = 3'd1;
   localparam logic [2:0] ST_OVER_AV   = 3'd2;
   localparam logic [2:0] ST_OVER_NEED = 3'd3;
   localparam logic [2:0] ST_DENIED    = 3'd4;
   localparam logic [2:0] ST_SEQ       = 3'd5;
   localparam logic [2:0] ST_UNSAFE    = 3'd6;

   typedef enum logic [3:0] {
      LC_NONE,
      LC_LOAD_AV,
      LC_LOAD_AL,
      LC_LOAD_ND,
      LC_GRANT,
      LC_INIT_WORK,
      LC_SCAN,
      LC_ROLLBACK,
      LC_RELEASE
   } lane_op_type;

   typedef struct packed {
      lane_op_type      op;
      logic [ROW_W-1:0] row;
      logic [7:0]       load_value;
      logic             take;
   } lane_cmd_type;

   typedef struct packed {
      logic fit;
      logic over_avail;
      logic over_need;
      logic need_zero;
   } lane_stat_type;

   typedef struct packed {
      logic fits_all;
      logic any_over_avail;
      logic any_over_need;
      logic all_need_zero;
   } merge_type;

   function automatic logic [UNIT_W-1:0] sat_add(input logic [UNIT_W-1:0] a,
                                                 input logic [UNIT_W-1:0] b);
      logic [UNIT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[UNIT_W] ? UNIT_MAX : s[UNIT_W-1:0];
   endfunction

endpackage

FILE: hdl/bsa_if.sv
// ----------------------------------------------------------------------------
// bsa_if: request and response channel interfaces
// Valid/ready channels carrying one request beat or one response beat.
// ----------------------------------------------------------------------------
interface bsa_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [2:0] process_index;
   logic [2:0] resource_index;
   logic [7:0] load_value;
   logic [7:0] req_0;
   logic [7:0] req_1;
   logic [7:0] req_2;
   logic [7:0] req_3;
   logic [7:0] req_4;
   logic [7:0] req_5;

   modport source (output valid, opcode, process_index, resource_index, load_value,
                   req_0, req_1, req_2, req_3, req_4, req_5, input ready);
   modport sink (input valid, opcode, process_index, resource_index, load_value,
                 req_0, req_1, req_2, req_3, req_4, req_5, output ready);
endinterface

interface bsa_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [2:0] proc_id;
   logic       last;

   modport source (output valid, status, proc_id, last, input ready);
   modport sink (input valid, status, proc_id, last, output ready);
endinterface

FILE: hdl/bsa_lane.sv
// ----------------------------------------------------------------------------
// bsa_lane: one resource column
// Holds available, allocation and need for one resource type plus its work
// entry, and compares the addressed row against them.
// ----------------------------------------------------------------------------
module bsa_lane
   import bsa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_cmd_type  cmd,
   input  logic          lane_en,
   input  logic [7:0]    req_units,
   output lane_stat_type stat
);

   logic [UNIT_W-1:0] avail_ff;
   logic [UNIT_W-1:0] work_ff;
   logic [UNIT_W-1:0] alloc_ff [MAX_PROCS];
   logic [UNIT_W-1:0] need_ff  [MAX_PROCS];
   logic [UNIT_W-1:0] save_av_ff, save_al_ff, save_nd_ff;

   logic [UNIT_W-1:0] alloc_row, need_row, req_ext, load_ext;

   assign alloc_row = alloc_ff[cmd.row];
   assign need_row  = need_ff[cmd.row];
   assign req_ext   = {{(UNIT_W-8){1'b0}}, req_units};
   assign load_ext  = {{(UNIT_W-8){1'b0}}, cmd.load_value};

   assign stat.fit        = (need_row <= work_ff);
   assign stat.over_avail = (req_ext > avail_ff);
   assign stat.over_need  = (req_ext > need_row);
   assign stat.need_zero  = (need_row == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         work_ff  <= '0;
         for (int i = 0; i < MAX_PROCS; i++) begin
            alloc_ff[i] <= '0;
            need_ff[i]  <= '0;
         end
      end else if (lane_en) begin
         case (cmd.op)
            LC_LOAD_AV:   avail_ff <= load_ext;
            LC_LOAD_AL:   alloc_ff[cmd.row] <= load_ext;
            LC_LOAD_ND:   need_ff[cmd.row] <= load_ext;
            LC_GRANT: begin
               avail_ff          <= avail_ff - req_ext;
               alloc_ff[cmd.row] <= sat_add(alloc_row, req_ext);
               need_ff[cmd.row]  <= need_row - req_ext;
            end
            LC_INIT_WORK: work_ff <= avail_ff;
            LC_SCAN: begin
               if (cmd.take) work_ff <= sat_add(work_ff, alloc_row);
            end
            LC_ROLLBACK: begin
               avail_ff          <= save_av_ff;
               alloc_ff[cmd.row] <= save_al_ff;
               need_ff[cmd.row]  <= save_nd_ff;
            end
            LC_RELEASE: begin
               avail_ff          <= sat_add(avail_ff, alloc_row);
               alloc_ff[cmd.row] <= '0;
            end
            default: ;
         endcase
      end
   end

   // prior values kept for an undo of a tentative grant
   always_ff @(posedge clock) begin
      if (lane_en && cmd.op == LC_GRANT) begin
         save_av_ff <= avail_ff;
         save_al_ff <= alloc_row;
         save_nd_ff <= need_row;
      end
   end

endmodule

FILE: hdl/bsa_merge.sv
// ----------------------------------------------------------------------------
// bsa_merge: combine lane findings
// Reduces per-lane compares over the resource types in use.
// ----------------------------------------------------------------------------
module bsa_merge
   import bsa_pkg::*;
(
   input  lane_stat_type      lane_stat [MAX_RES],
   input  logic [MAX_RES-1:0] active,
   output merge_type          merged
);

   always_comb begin
      merged.fits_all       = 1'b1;
      merged.any_over_avail = 1'b0;
      merged.any_over_need  = 1'b0;
      merged.all_need_zero  = 1'b1;
      for (int i = 0; i < MAX_RES; i++) begin
         if (active[i]) begin
            merged.fits_all       = merged.fits_all & lane_stat[i].fit;
            merged.any_over_avail = merged.any_over_avail | lane_stat[i].over_avail;
            merged.any_over_need  = merged.any_over_need | lane_stat[i].over_need;
            merged.all_need_zero  = merged.all_need_zero & lane_stat[i].need_zero;
         end
      end
   end

endmodule

FILE: hdl/banker_safety_allocator.sv
// ----------------------------------------------------------------------------
// banker_safety_allocator: deadlock avoidance by the banker's algorithm
// Available/Allocation/Need tables in six resource lanes, safety scanner,
// request grant with rollback, and an APB-style register port.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Loads and rejected requests pass through idle,
// decode and emit from one accepted beat to the next; an undefined opcode is
// dropped at decode. A safety check, or a request that passes its bounds
// checks, runs the scanner after idle, decode and prepare: one process is
// tested per cycle, with all resource lanes comparing in parallel, for up to
// proc_count passes, followed by resolve and emit. A safe check streams one
// response beat per cycle for each process, while the response channel does
// not stall, in place of the single emit beat. Response stalls hold the emit
// and stream states. The scanner loop sets the rate.
// The tables clear at reset; registers read back at byte address 0 and 4.
// ----------------------------------------------------------------------------
module banker_safety_allocator
   import bsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bsa_req_if.sink     req_chan,
   bsa_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_DECODE  = 7'b0000010,
      S_PREP    = 7'b0000100,
      S_SCAN    = 7'b0001000,
      S_RESOLVE = 7'b0010000,
      S_EMIT    = 7'b0100000,
      S_SEQ     = 7'b1000000
   } state_type;

   // ---------------- register port ----------------
   logic [3:0] proc_count_ff;
   logic [2:0] res_count_ff;

   assign pready = 1'b1;
   assign prdata = paddr[2] ? {29'd0, res_count_ff} : {28'd0, proc_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_count_ff <= 4'd1;
         res_count_ff  <= 3'd1;
      end else if (psel && penable && pwrite) begin
         if (paddr[2]) res_count_ff  <= pwdata[2:0];
         else          proc_count_ff <= pwdata[3:0];
      end
   end

   // effective counts: zero acts as one, above max acts as max
   logic [3:0]       np_eff;
   logic [2:0]       nr_eff;
   logic [ROW_W-1:0] np_m1;
   logic [MAX_RES-1:0] active;

   always_comb begin
      if (proc_count_ff == 4'd0)                  np_eff = 4'd1;
      else if (proc_count_ff > 4'(MAX_PROCS))     np_eff = 4'(MAX_PROCS);
      else                                        np_eff = proc_count_ff;
      if (res_count_ff == 3'd0)                   nr_eff = 3'd1;
      else if (res_count_ff > 3'(MAX_RES))        nr_eff = 3'(MAX_RES);
      else                                        nr_eff = res_count_ff;
      np_m1 = ROW_W'(np_eff - 4'd1);
      for (int i = 0; i < MAX_RES; i++) active[i] = (3'(i) < nr_eff);
   end

   // ---------------- control state ----------------
   state_type        state_ff, state_in;
   logic [2:0]       op_ff;
   logic [ROW_W-1:0] pidx_ff;
   logic [2:0]       ridx_ff;
   logic [7:0]       val_ff;
   logic [7:0]       req_ff [MAX_RES];

   logic [MAX_PROCS-1:0] finished_ff;
   logic [ROW_W-1:0]     safe_order_ff [MAX_PROCS];
   logic [ROW_W-1:0]     scan_p_ff;
   logic [ROW_W-1:0]     pass_ff;
   logic [3:0]           done_ff, before_ff;
   logic [ROW_W-1:0]     seq_k_ff;
   logic [2:0]           pend_status_ff;

   logic       rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [2:0] rsp_pid_ff;
   logic       rsp_last_ff;

   lane_cmd_type       cmd;
   logic [MAX_RES-1:0] lane_en;
   lane_stat_type      lane_stat [MAX_RES];
   merge_type          merged;

   logic       out_free;
   logic       take;
   logic [3:0] done_in;
   logic       scan_end;
   logic       safe;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.proc_id = rsp_pid_ff;
   assign rsp_chan.last    = rsp_last_ff;

   // an unfinished process whose need fits the work vector finishes now
   assign take     = (state_ff == S_SCAN) && merged.fits_all && !finished_ff[scan_p_ff];
   assign done_in  = done_ff + {3'd0, take};
   // stop at the last process of a pass when all finished, none advanced,
   // or the pass budget is used up
   assign scan_end = (scan_p_ff == np_m1) &&
                     (done_in == np_eff || done_in == before_ff || pass_ff == np_m1);
   assign safe     = (done_ff == np_eff);

   // ---------------- lane command and next state ----------------
   always_comb begin
      state_in       = state_ff;
      cmd.op         = LC_NONE;
      cmd.row        = pidx_ff;
      cmd.load_value = val_ff;
      cmd.take       = take;
      lane_en        = active;
      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (op_ff)
               OP_LOAD_AV, OP_LOAD_AL, OP_LOAD_ND: begin
                  if (op_ff == OP_LOAD_AV)      cmd.op = LC_LOAD_AV;
                  else if (op_ff == OP_LOAD_AL) cmd.op = LC_LOAD_AL;
                  else                          cmd.op = LC_LOAD_ND;
                  for (int i = 0; i < MAX_RES; i++) lane_en[i] = (ridx_ff == 3'(i));
                  state_in = S_EMIT;
               end
               OP_CHECK: state_in = S_PREP;
               OP_REQUEST: begin
                  if ({1'b0, pidx_ff} >= np_eff || merged.any_over_avail ||
                      merged.any_over_need) begin
                     state_in = S_EMIT;
                  end else begin
                     cmd.op   = LC_GRANT;
                     state_in = S_PREP;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PREP: begin
            cmd.op   = LC_INIT_WORK;
            lane_en  = '1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op  = LC_SCAN;
            cmd.row = scan_p_ff;
            if (scan_end) state_in = S_RESOLVE;
         end
         S_RESOLVE: begin
            if (op_ff == OP_CHECK) begin
               state_in = safe ? S_SEQ : S_EMIT;
            end else begin
               if (!safe)                    cmd.op = LC_ROLLBACK;
               else if (merged.all_need_zero) cmd.op = LC_RELEASE;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         S_SEQ: begin
            if (out_free && seq_k_ff == np_m1) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------- lanes and merge ----------------
   for (genvar g = 0; g < MAX_RES; g++) begin : g_lane
      bsa_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .lane_en   (lane_en[g]),
         .req_units (req_ff[g]),
         .stat      (lane_stat[g])
      );
   end

   bsa_merge u_merge (
      .lane_stat (lane_stat),
      .active    (active),
      .merged    (merged)
   );

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         finished_ff  <= '0;
         done_ff      <= '0;
         before_ff    <= '0;
         scan_p_ff    <= '0;
         pass_ff      <= '0;
         seq_k_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // raise valid when a beat is loaded, drop it once taken
         if ((state_ff == S_EMIT || state_ff == S_SEQ) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_PREP: begin
               finished_ff <= '0;
               done_ff     <= '0;
               before_ff   <= '0;
               scan_p_ff   <= '0;
               pass_ff     <= '0;
            end
            S_SCAN: begin
               done_ff <= done_in;
               if (take) finished_ff[scan_p_ff] <= 1'b1;
               if (scan_p_ff == np_m1) begin
                  // wrap to the next pass
                  scan_p_ff <= '0;
                  pass_ff   <= pass_ff + ROW_W'(1);
                  before_ff <= done_in;
               end else begin
                  scan_p_ff <= scan_p_ff + ROW_W'(1);
               end
            end
            S_RESOLVE: seq_k_ff <= '0;
            S_SEQ: begin
               if (out_free) seq_k_ff <= seq_k_ff + ROW_W'(1);
            end
            default: ;
         endcase
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      // capture the request beat
      if (state_ff == S_IDLE && req_chan.valid) begin
         op_ff     <= req_chan.opcode;
         pidx_ff   <= req_chan.process_index;
         ridx_ff   <= req_chan.resource_index;
         val_ff    <= req_chan.load_value;
         req_ff[0] <= req_chan.req_0;
         req_ff[1] <= req_chan.req_1;
         req_ff[2] <= req_chan.req_2;
         req_ff[3] <= req_chan.req_3;
         req_ff[4] <= req_chan.req_4;
         req_ff[5] <= req_chan.req_5;
      end
      // record the safe sequence as processes finish
      if (take) safe_order_ff[done_ff[ROW_W-1:0]] <= scan_p_ff;
      // pick the single-beat status
      if (state_ff == S_DECODE) begin
         if (op_ff == OP_REQUEST) begin
            if ({1'b0, pidx_ff} >= np_eff) pend_status_ff <= ST_OVER_NEED;
            else if (merged.any_over_avail) pend_status_ff <= ST_OVER_AV;
            else                            pend_status_ff <= ST_OVER_NEED;
         end else begin
            pend_status_ff <= ST_LOADED;
         end
      end
      if (state_ff == S_RESOLVE) begin
         if (op_ff == OP_CHECK) pend_status_ff <= ST_UNSAFE;
         else                   pend_status_ff <= safe ? ST_GRANTED : ST_DENIED;
      end
      // load the response register
      if (state_ff == S_EMIT && out_free) begin
         rsp_status_ff <= pend_status_ff;
         rsp_pid_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end
      if (state_ff == S_SEQ && out_free) begin
         rsp_status_ff <= ST_SEQ;
         rsp_pid_ff    <= safe_order_ff[seq_k_ff];
         rsp_last_ff   <= (seq_k_ff == np_m1);
      end
   end

   // ---------------- assertions ----------------
   // finished flags and the finish count move together
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      ($countones(finished_ff) == done_ff))
      else $error("finish count out of step with finished flags");

   // never more finished processes than processes in use
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_RESOLVE) |-> (done_ff <= np_eff))
      else $error("finish count exceeds process count");

   // every response beat but a sequence entry closes its request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_SEQ) |-> rsp_last_ff)
      else $error("single-beat response without last");

   // a response beat is loaded only after the scanner or decode has settled
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT || $past(state_ff) == S_SEQ))
      else $error("response loaded outside an emit state");

endmodule

FILE: bench/banker_safety_allocator_tb.sv
// ----------------------------------------------------------------------------
// banker_safety_allocator_tb: self-checking bench for the banker allocator
// Loads Available/Allocation/Need entries, runs safety checks and resource
// requests under several process/resource counts, and scores every response
// beat against a banker's-algorithm ledger kept inside the bench.
// ----------------------------------------------------------------------------
module banker_safety_allocator_tb;
   import bsa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // register map: index i sits at byte address 4*i
   localparam int REG_PROC_COUNT = 0;
   localparam int REG_RES_COUNT  = 1;

   // highest opcode the 3-bit field can carry; codes above OP_REQUEST are undefined
   localparam logic [2:0] OP_TOP = '1;

   // cycles to let pass once the last expected beat is in, so that ignored
   // beats and the tail of a scan have left the block
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [2:0]              opcode;
      logic [2:0]              proc_idx;
      logic [2:0]              res_idx;
      logic [7:0]              load_value;
      logic [MAX_RES-1:0][7:0] units;
   } alloc_beat_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] proc_id;
      logic       last;
   } verdict_type;

   // -------------------------------------------------------------------------
   // Ledger: own copy of the tables and counts, and the beats still owed
   // -------------------------------------------------------------------------
   class banker_ledger_type;
      int unsigned       proc_reg;
      int unsigned       res_reg;
      logic [UNIT_W-1:0] avail [MAX_RES];
      logic [UNIT_W-1:0] alloc [MAX_PROCS][MAX_RES];
      logic [UNIT_W-1:0] need  [MAX_PROCS][MAX_RES];
      verdict_type       owed_beats [$];
      int unsigned       errors;
      int unsigned       beats_seen;
      int unsigned       n_granted;
      int unsigned       n_rejected;
      int unsigned       n_denied;
      int unsigned       n_safe;
      int unsigned       n_unsafe;

      function new();
         proc_reg = 1;
         res_reg  = 1;
         foreach (avail[r]) avail[r] = '0;
         foreach (alloc[p, r]) begin
            alloc[p][r] = '0;
            need[p][r]  = '0;
         end
         errors     = 0;
         beats_seen = 0;
         n_granted  = 0;
         n_rejected = 0;
         n_denied   = 0;
         n_safe     = 0;
         n_unsafe   = 0;
      endfunction

      // a zero count acts as one, an oversize count as the table size
      function int unsigned procs_live();
         if (proc_reg == 0) return 1;
         return (proc_reg > MAX_PROCS) ? MAX_PROCS : proc_reg;
      endfunction

      function int unsigned res_live();
         if (res_reg == 0) return 1;
         return (res_reg > MAX_RES) ? MAX_RES : res_reg;
      endfunction

      function void write_reg(int idx, logic [31:0] value);
         if (idx == REG_PROC_COUNT) proc_reg = 32'(value[3:0]);
         else if (idx == REG_RES_COUNT) res_reg = 32'(value[2:0]);
      endfunction

      function logic [31:0] reg_value(int idx);
         return (idx == REG_PROC_COUNT) ? 32'(proc_reg) : 32'(res_reg);
      endfunction

      function logic [UNIT_W-1:0] clip_add(logic [UNIT_W-1:0] a, logic [UNIT_W-1:0] b);
         logic [UNIT_W:0] total;
         total = {1'b0, a} + {1'b0, b};
         return (total > UNIT_MAX) ? UNIT_MAX : total[UNIT_W-1:0];
      endfunction

      // Passes in process order; each unfinished process whose need fits the
      // work vector hands its allocation back. Returns how many finished.
      function int unsigned safe_sequence(output logic [2:0] order [MAX_PROCS]);
         logic [UNIT_W-1:0] work [MAX_RES];
         bit                finished [MAX_PROCS];
         int unsigned       np, nr, done, prior;
         int                pass, p, r;
         bit                fits;
         np   = procs_live();
         nr   = res_live();
         done = 0;
         foreach (work[i]) work[i] = avail[i];
         foreach (finished[i]) begin
            finished[i] = 1'b0;
            order[i]    = '0;
         end
         for (pass = 0; pass < np && done < np; pass++) begin
            prior = done;
            for (p = 0; p < np; p++) begin
               if (!finished[p]) begin
                  fits = 1'b1;
                  for (r = 0; r < nr; r++)
                     if (need[p][r] > work[r]) fits = 1'b0;
                  if (fits) begin
                     for (r = 0; r < nr; r++) work[r] = clip_add(work[r], alloc[p][r]);
                     finished[p] = 1'b1;
                     order[done] = p[2:0];
                     done++;
                  end
               end
            end
            if (done == prior) break;
         end
         return done;
      endfunction

      function void owe(logic [2:0] status, logic [2:0] pid, logic last);
         verdict_type v;
         v.status  = status;
         v.proc_id = pid;
         v.last    = last;
         owed_beats.insert(owed_beats.size(), v);
      endfunction

      // Apply one accepted input beat and queue the response beats it owes.
      function void book_op(alloc_beat_type b);
         logic [2:0]        order [MAX_PROCS];
         logic [UNIT_W-1:0] keep_av [MAX_RES];
         logic [UNIT_W-1:0] keep_al [MAX_RES];
         logic [UNIT_W-1:0] keep_nd [MAX_RES];
         int unsigned       np, nr;
         int                p, r, i;
         bit                over_av, over_nd, all_zero;
         np = procs_live();
         nr = res_live();
         p  = int'(b.proc_idx);
         r  = int'(b.res_idx);
         case (b.opcode)
            OP_LOAD_AV: begin
               if (r < MAX_RES) avail[r] = 12'(b.load_value);
               owe(ST_LOADED, '0, 1'b1);
            end
            OP_LOAD_AL: begin
               if (r < MAX_RES) alloc[p][r] = 12'(b.load_value);
               owe(ST_LOADED, '0, 1'b1);
            end
            OP_LOAD_ND: begin
               if (r < MAX_RES) need[p][r] = 12'(b.load_value);
               owe(ST_LOADED, '0, 1'b1);
            end
            OP_CHECK: begin
               if (safe_sequence(order) < np) begin
                  n_unsafe++;
                  owe(ST_UNSAFE, '0, 1'b1);
               end else begin
                  n_safe++;
                  for (i = 0; i < np; i++) owe(ST_SEQ, order[i], i == np - 1);
               end
            end
            OP_REQUEST: begin
               if (p >= np) begin
                  n_rejected++;
                  owe(ST_OVER_NEED, '0, 1'b1);
                  return;
               end
               over_av = 1'b0;
               over_nd = 1'b0;
               for (i = 0; i < nr; i++) begin
                  if (b.units[i] > avail[i]) over_av = 1'b1;
                  if (b.units[i] > need[p][i]) over_nd = 1'b1;
               end
               if (over_av || over_nd) begin
                  n_rejected++;
                  owe(over_av ? ST_OVER_AV : ST_OVER_NEED, '0, 1'b1);
                  return;
               end
               // grant tentatively, keep the old row to undo it
               for (i = 0; i < nr; i++) begin
                  keep_av[i]  = avail[i];
                  keep_al[i]  = alloc[p][i];
                  keep_nd[i]  = need[p][i];
                  avail[i]    = avail[i] - b.units[i];
                  alloc[p][i] = clip_add(alloc[p][i], 12'(b.units[i]));
                  need[p][i]  = need[p][i] - b.units[i];
               end
               if (safe_sequence(order) < np) begin
                  for (i = 0; i < nr; i++) begin
                     avail[i]    = keep_av[i];
                     alloc[p][i] = keep_al[i];
                     need[p][i]  = keep_nd[i];
                  end
                  n_denied++;
                  owe(ST_DENIED, '0, 1'b1);
                  return;
               end
               all_zero = 1'b1;
               for (i = 0; i < nr; i++)
                  if (need[p][i] != '0) all_zero = 1'b0;
               if (all_zero) begin
                  for (i = 0; i < nr; i++) begin
                     avail[i]    = clip_add(avail[i], alloc[p][i]);
                     alloc[p][i] = '0;
                  end
               end
               n_granted++;
               owe(ST_GRANTED, '0, 1'b1);
            end
            default: ;
         endcase
      endfunction

      function void match_beat(verdict_type got);
         verdict_type want;
         beats_seen++;
         if (owed_beats.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing owed: status=%0d proc_id=%0d last=%0d",
                     $time, got.status, got.proc_id, got.last);
            return;
         end
         want = owed_beats.pop_front();
         if (got.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
         end
         if (got.proc_id !== want.proc_id) begin
            errors++;
            $display("%0t: proc_id expected %0d, got %0d", $time, want.proc_id, got.proc_id);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %0d, got %0d", $time, want.last, got.last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block, channels and register port
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bsa_req_if req_chan ();
   bsa_rsp_if rsp_chan ();

   banker_safety_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   banker_ledger_type book;
   bit           quiet;          // when set, neither side idles
   int unsigned  items_sent;     // beats the block acts on
   int unsigned  ignored_sent;   // beats with an undefined opcode
   int unsigned  n_settings;

   always #1 clock = ~clock;

   // Hard stop in case a handshake never completes.
   initial begin
      #1ms;
      $display("banker_safety_allocator_tb failed");
      $finish;
   end

   // Gap before a request beat or stall before taking a response beat.
   function automatic int unsigned pick_gap();
      return quiet ? 0 : $urandom_range(0, 8);
   endfunction

   // Fully random beat; callers overwrite the fields they care about so the
   // don't-care fields still toggle every bit.
   function automatic alloc_beat_type random_beat();
      alloc_beat_type b;
      b.opcode     = 3'($urandom_range(0, OP_TOP));
      b.proc_idx   = 3'($urandom_range(0, MAX_PROCS - 1));
      b.res_idx    = 3'($urandom_range(0, 7));
      b.load_value = 8'($urandom_range(0, 255));
      foreach (b.units[i]) b.units[i] = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // -------------------------------------------------------------------------
   // Request side: hold valid across back-to-back beats, drop it on a gap
   // -------------------------------------------------------------------------
   task automatic push_beat(input alloc_beat_type b);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.opcode         <= b.opcode;
      req_chan.process_index  <= b.proc_idx;
      req_chan.resource_index <= b.res_idx;
      req_chan.load_value     <= b.load_value;
      req_chan.req_0          <= b.units[0];
      req_chan.req_1          <= b.units[1];
      req_chan.req_2          <= b.units[2];
      req_chan.req_3          <= b.units[3];
      req_chan.req_4          <= b.units[4];
      req_chan.req_5          <= b.units[5];
      req_chan.valid          <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      book.book_op(b);
      if (b.opcode > OP_REQUEST) ignored_sent++;
      else items_sent++;
   endtask

   task automatic load_entry(input logic [2:0] op, input logic [2:0] p, input logic [2:0] r,
                             input logic [7:0] value);
      alloc_beat_type b;
      b            = random_beat();
      b.opcode     = op;
      b.proc_idx   = p;
      b.res_idx    = r;
      b.load_value = value;
      push_beat(b);
   endtask

   task automatic run_check();
      alloc_beat_type b;
      b        = random_beat();
      b.opcode = OP_CHECK;
      push_beat(b);
   endtask

   task automatic ask(input logic [2:0] p, input logic [MAX_RES-1:0][7:0] units);
      alloc_beat_type b;
      b          = random_beat();
      b.opcode   = OP_REQUEST;
      b.proc_idx = p;
      b.units    = units;
      push_beat(b);
   endtask

   // Drop valid, wait for every owed beat, then let the block settle.
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (book.owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register port: setup then access, pready honored though always high
   // -------------------------------------------------------------------------
   task automatic csr_cycle(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_csr(input int idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_cycle(1'b1, 3'(idx * 4), value, rd);
      book.write_reg(idx, value);
      csr_cycle(1'b0, 3'(idx * 4), '0, rd);
      if (rd !== book.reg_value(idx)) begin
         book.errors++;
         $display("%0t: register %0d read back expected %0d, got %0d",
                  $time, idx, book.reg_value(idx), rd);
      end
   endtask

   // Counts change only with the block idle.
   task automatic program_counts(input int unsigned procs, input int unsigned kinds);
      drain();
      write_csr(REG_PROC_COUNT, procs);
      write_csr(REG_RES_COUNT, kinds);
      n_settings++;
   endtask

   // -------------------------------------------------------------------------
   // Random traffic: short bursts of loads followed by checks and requests.
   // Needs and requests are kept smaller than Available so that safe states
   // and grants stay common; a slice of raw noise rides along.
   // -------------------------------------------------------------------------
   task automatic random_phase(input int unsigned budget);
      alloc_beat_type             b;
      logic [MAX_RES-1:0][7:0]    units;
      int unsigned                np, nr, scale, stop_at, i;
      np      = book.procs_live();
      nr      = book.res_live();
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         quiet = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0:       scale = 3;
            1:       scale = 15;
            2:       scale = 63;
            default: scale = 255;
         endcase
         if ($urandom_range(0, 7) == 0) begin
            // noise: anything goes, undefined opcodes included
            repeat ($urandom_range(1, 4)) push_beat(random_beat());
         end else begin
            repeat ($urandom_range(1, 10)) begin
               b        = random_beat();
               b.opcode = 3'($urandom_range(OP_LOAD_AV, OP_LOAD_ND));
               if ($urandom_range(0, 7) != 0) begin
                  b.proc_idx = 3'($urandom_range(0, np - 1));
                  b.res_idx  = 3'($urandom_range(0, nr - 1));
               end
               b.load_value = (b.opcode == OP_LOAD_AV) ? 8'($urandom_range(0, scale))
                                                       : 8'($urandom_range(0, scale >> 1));
               push_beat(b);
            end
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 2) == 0) begin
                  run_check();
               end else begin
                  b = random_beat();
                  if ($urandom_range(0, 7) != 0) b.proc_idx = 3'($urandom_range(0, np - 1));
                  units = b.units;
                  if ($urandom_range(0, 5) != 0)
                     for (i = 0; i < MAX_RES; i++) units[i] = 8'($urandom_range(0, scale >> 1));
                  ask(b.proc_idx, units);
               end
            end
         end
      end
      quiet = 1'b0;
   endtask

   // Pump one allocation toward the 12-bit ceiling: refill Available and
   // Need for resource 0 and grant the full amount again and again, while a
   // nonzero Need in resource 1 keeps the process from releasing.
   task automatic saturate_alloc();
      logic [MAX_RES-1:0][7:0] units;
      int unsigned             p, r;
      for (p = 0; p < book.procs_live(); p++)
         for (r = 0; r < book.res_live(); r++)
            load_entry(OP_LOAD_ND, p[2:0], r[2:0], 8'd0);
      load_entry(OP_LOAD_AV, 3'd0, 3'd1, 8'd255);
      load_entry(OP_LOAD_ND, 3'd0, 3'd1, 8'd1);
      units    = '0;
      units[0] = 8'd255;
      repeat (18) begin
         load_entry(OP_LOAD_AV, 3'd0, 3'd0, 8'd255);
         load_entry(OP_LOAD_ND, 3'd0, 3'd0, 8'd255);
         ask(3'd0, units);
      end
      run_check();
      // clear the last unit of need: release the saturated row into Available
      units    = '0;
      units[1] = 8'd1;
      ask(3'd0, units);
      run_check();
   endtask

   // Score every response beat taken at a clock edge.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         book.match_beat({rsp_chan.status, rsp_chan.proc_id, rsp_chan.last});
   end

   // Response side: stall a random number of cycles before each beat.
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [MAX_RES-1:0][7:0] units;
      logic [2:0]              op;
      book         = new();
      quiet        = 1'b0;
      items_sent   = 0;
      ignored_sent = 0;
      n_settings   = 1;
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.opcode         <= '0;
      req_chan.process_index  <= '0;
      req_chan.resource_index <= '0;
      req_chan.load_value     <= '0;
      req_chan.req_0          <= '0;
      req_chan.req_1          <= '0;
      req_chan.req_2          <= '0;
      req_chan.req_3          <= '0;
      req_chan.req_4          <= '0;
      req_chan.req_5          <= '0;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset counts (one process, one resource) ---
      run_check();                                     // all-zero tables are safe
      load_entry(OP_LOAD_AV, 3'd0, 3'd0, 8'd255);
      load_entry(OP_LOAD_AV, 3'd0, 3'd7, 8'd255);      // column past the table: dropped
      load_entry(OP_LOAD_AL, 3'd7, 3'd6, 8'd9);        // column past the table: dropped
      load_entry(OP_LOAD_ND, 3'd0, 3'd0, 8'd200);
      units = '0;
      ask(3'd1, units);                                // process not in use
      units[0] = 8'd255;
      ask(3'd0, units);                                // over need
      load_entry(OP_LOAD_AV, 3'd0, 3'd0, 8'd100);
      units[0] = 8'd150;
      ask(3'd0, units);                                // over available
      units[0] = 8'd100;
      ask(3'd0, units);                                // unsafe: roll back
      run_check();                                     // prior state still unsafe
      load_entry(OP_LOAD_ND, 3'd0, 3'd0, 8'd50);
      units[0] = 8'd50;
      ask(3'd0, units);                                // grant, need hits zero: release
      run_check();
      for (op = OP_REQUEST + 3'd1; op != 3'd0; op++) begin
         load_entry(op, 3'd0, 3'd0, 8'd0);             // undefined opcodes: no beat
      end
      units = '0;
      ask(3'd0, units);                                // empty request
      random_phase(20);

      // --- full size ---
      program_counts(MAX_PROCS, MAX_RES);
      load_entry(OP_LOAD_ND, 3'd7, 3'd5, 8'd255);
      run_check();                                     // last process can never fit
      ask(3'd7, '0);                                   // still unsafe: denied, rolled back
      load_entry(OP_LOAD_ND, 3'd7, 3'd5, 8'd0);
      run_check();
      random_phase(60);

      // --- small table, then saturation ---
      program_counts(2, 2);
      saturate_alloc();
      random_phase(30);

      // --- zero counts act as one ---
      program_counts(0, 0);
      random_phase(20);

      // --- oversize counts clamp to the table size ---
      program_counts(15, 7);
      random_phase(60);

      program_counts(3, 4);
      random_phase(35);

      program_counts(9, 1);
      random_phase(35);

      program_counts(5, 3);
      random_phase(35);

      drain();

      $display("Covered %0d beats plus %0d undefined-opcode beats under %0d count settings.",
               items_sent, ignored_sent, n_settings);
      $display("%0d beats scored: %0d granted, %0d rejected, %0d denied, %0d safe, %0d unsafe",
               book.beats_seen, book.n_granted, book.n_rejected, book.n_denied,
               book.n_safe, book.n_unsafe);
      if (book.errors == 0) begin
         $display("banker_safety_allocator_tb passed");
      end else begin
         $display("banker_safety_allocator_tb failed");
      end
      $finish;
   end

endmodule
